// File: rtl/erm_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler rotation matrix block.
`default_nettype none
package erm_pkg;

  localparam int VW = 31;
  localparam int PW = 62;
  localparam int RW = 63;

  localparam logic [VW-1:0] ONE = 31'd1073741824;
  localparam logic [18:0] RAD_PER_UNIT = 19'd292818;

  localparam logic [31:0] RECIP_42 = 32'd102261126;
  localparam logic [31:0] RECIP_56 = 32'd76695844;
  localparam logic [31:0] RECIP_20 = 32'd214748364;
  localparam logic [31:0] RECIP_30 = 32'd143165576;
  localparam logic [31:0] RECIP_6  = 32'd715827882;
  localparam logic [31:0] RECIP_12 = 32'd357913941;

  localparam logic signed [15:0] Q14_POS = 16'sd16384;
  localparam logic signed [15:0] Q14_NEG = -16'sd16384;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } side_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  // Q30 product back to Q30, round half up
  function automatic logic [VW-1:0] rnd30(input logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = p + 62'd536870912;
    return t[60:30];
  endfunction

  // exact (t / n) from reciprocal estimate that is at most one low
  function automatic logic [VW-1:0] div_fix(input logic [VW-1:0] t,
                                            input logic [RW-1:0] prod,
                                            input logic [5:0] n);
    logic [VW-1:0] q0;
    logic [36:0]   qn;
    logic [36:0]   r;
    q0 = prod[62:32];
    qn = {6'd0, q0} * {31'd0, n};
    r  = {6'd0, t} - qn;
    return (r >= {31'd0, n}) ? q0 + 31'd1 : q0;
  endfunction

  function automatic logic signed [15:0] to_q14(input logic [VW-1:0] v);
    logic [VW-1:0] t;
    t = v + 31'd32768;
    return $signed({1'b0, t[30:16]});
  endfunction

  // Q42 to Q1.14, round half up, saturate to plus or minus one
  function automatic logic signed [15:0] finish(input logic signed [47:0] v);
    logic signed [47:0] t;
    logic signed [19:0] r;
    t = v + 48'sd134217728;
    r = 20'(t >>> 28);
    if (r > 20'sd16384) return Q14_POS;
    if (r < -20'sd16384) return Q14_NEG;
    return 16'(r);
  endfunction

endpackage
`default_nettype wire

// File: rtl/erm_sincos.sv
// One angle lane: range reduction and pipelined Taylor sine and cosine in Q1.14.
`default_nettype none
module erm_sincos (
  input  wire logic               clk,
  input  wire logic [12:0]        en,
  input  wire logic signed [15:0] angle,
  output logic signed [15:0]      sin_r,
  output logic signed [15:0]      cos_r
);

  localparam int VW = erm_pkg::VW;
  localparam int PW = erm_pkg::PW;
  localparam int RW = erm_pkg::RW;

  // range reduction
  logic signed [16:0] a17, r1, r2;
  logic [14:0]        rr;
  logic [1:0]         quad;
  logic [12:0]        f;
  logic [11:0]        u;
  erm_pkg::side_t     side_in;

  always_comb begin
    a17 = 17'(angle);
    if (a17 < 17'sd0) begin
      r1 = a17 + 17'sd23040;
    end else if (a17 >= 17'sd23040) begin
      r1 = a17 - 17'sd23040;
    end else begin
      r1 = a17;
    end
    r2 = (r1 < 17'sd0) ? r1 + 17'sd23040 : r1;
    rr = r2[14:0];
    if (rr >= 15'd17280) begin
      quad = 2'd3;
      f = 13'(rr - 15'd17280);
    end else if (rr >= 15'd11520) begin
      quad = 2'd2;
      f = 13'(rr - 15'd11520);
    end else if (rr >= 15'd5760) begin
      quad = 2'd1;
      f = 13'(rr - 15'd5760);
    end else begin
      quad = 2'd0;
      f = 13'(rr);
    end
    side_in.quad = quad;
    side_in.swap = (f > 13'd2880);
    u = side_in.swap ? 12'(13'd5760 - f) : f[11:0];
  end

  erm_pkg::side_t side_r [0:11];
  logic [11:0]   u0_r;
  logic [VW-1:0] xk_r [1:10];
  logic [VW-1:0] x2_r [3:10];
  logic [PW-1:0] pxx2_r;
  logic [VW-1:0] ts3_r, tc3_r, ts6_r, tc6_r, ts9_r, tc9_r;
  logic [RW-1:0] ms3_r, mc3_r, ms6_r, mc6_r, ms9_r, mc9_r;
  logic [VW-1:0] s4_r, c4_r, s7_r, c7_r, s10_r, c10_r;
  logic [PW-1:0] ps5_r, pc5_r, ps8_r, pc8_r, ps11_r, pc11_r;

  logic [VW-1:0] x2_nxt, ts6_nxt, tc6_nxt, ts9_nxt, tc9_nxt;

  always_comb begin
    x2_nxt  = erm_pkg::rnd30(pxx2_r);
    ts6_nxt = erm_pkg::rnd30(ps5_r) + 31'd10;
    tc6_nxt = erm_pkg::rnd30(pc5_r) + 31'd15;
    ts9_nxt = erm_pkg::rnd30(ps8_r) + 31'd3;
    tc9_nxt = erm_pkg::rnd30(pc8_r) + 31'd6;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u0_r      <= u;
      side_r[0] <= side_in;
    end
    for (int i = 1; i < 12; i++) begin
      if (en[i]) side_r[i] <= side_r[i-1];
    end
    for (int i = 2; i < 11; i++) begin
      if (en[i]) xk_r[i] <= xk_r[i-1];
    end
    for (int i = 4; i < 11; i++) begin
      if (en[i]) x2_r[i] <= x2_r[i-1];
    end
    if (en[1]) xk_r[1] <= VW'(31'(u0_r) * 31'(erm_pkg::RAD_PER_UNIT));
    if (en[2]) pxx2_r <= PW'(xk_r[1]) * PW'(xk_r[1]);
    if (en[3]) begin
      x2_r[3] <= x2_nxt;
      ts3_r   <= x2_nxt + 31'd21;
      tc3_r   <= x2_nxt + 31'd28;
      ms3_r   <= RW'(x2_nxt + 31'd21) * RW'(erm_pkg::RECIP_42);
      mc3_r   <= RW'(x2_nxt + 31'd28) * RW'(erm_pkg::RECIP_56);
    end
    if (en[4]) begin
      s4_r <= erm_pkg::ONE - erm_pkg::div_fix(ts3_r, ms3_r, 6'd42);
      c4_r <= erm_pkg::ONE - erm_pkg::div_fix(tc3_r, mc3_r, 6'd56);
    end
    if (en[5]) begin
      ps5_r <= PW'(x2_r[4]) * PW'(s4_r);
      pc5_r <= PW'(x2_r[4]) * PW'(c4_r);
    end
    if (en[6]) begin
      ts6_r <= ts6_nxt;
      tc6_r <= tc6_nxt;
      ms6_r <= RW'(ts6_nxt) * RW'(erm_pkg::RECIP_20);
      mc6_r <= RW'(tc6_nxt) * RW'(erm_pkg::RECIP_30);
    end
    if (en[7]) begin
      s7_r <= erm_pkg::ONE - erm_pkg::div_fix(ts6_r, ms6_r, 6'd20);
      c7_r <= erm_pkg::ONE - erm_pkg::div_fix(tc6_r, mc6_r, 6'd30);
    end
    if (en[8]) begin
      ps8_r <= PW'(x2_r[7]) * PW'(s7_r);
      pc8_r <= PW'(x2_r[7]) * PW'(c7_r);
    end
    if (en[9]) begin
      ts9_r <= ts9_nxt;
      tc9_r <= tc9_nxt;
      ms9_r <= RW'(ts9_nxt) * RW'(erm_pkg::RECIP_6);
      mc9_r <= RW'(tc9_nxt) * RW'(erm_pkg::RECIP_12);
    end
    if (en[10]) begin
      s10_r <= erm_pkg::ONE - erm_pkg::div_fix(ts9_r, ms9_r, 6'd6);
      c10_r <= erm_pkg::ONE - erm_pkg::div_fix(tc9_r, mc9_r, 6'd12);
    end
    if (en[11]) begin
      ps11_r <= PW'(xk_r[10]) * PW'(s10_r);
      pc11_r <= PW'(x2_r[10]) * PW'(c10_r);
    end
  end

  // final cosine step, octant swap and quadrant map
  logic [VW-1:0]      cm;
  logic [31:0]        chalf;
  logic signed [15:0] os, oc, ps, pc, sin_nxt, cos_nxt;

  always_comb begin
    cm    = erm_pkg::rnd30(pc11_r);
    chalf = 32'(cm) + 32'd1;
    ps    = erm_pkg::to_q14(ps11_r == '0 ? '0 : erm_pkg::rnd30(ps11_r));
    pc    = erm_pkg::to_q14(erm_pkg::ONE - chalf[31:1]);
    os    = side_r[11].swap ? pc : ps;
    oc    = side_r[11].swap ? ps : pc;
    case (side_r[11].quad)
      2'd0: begin
        sin_nxt = os;
        cos_nxt = oc;
      end
      2'd1: begin
        sin_nxt = oc;
        cos_nxt = -os;
      end
      2'd2: begin
        sin_nxt = -os;
        cos_nxt = -oc;
      end
      default: begin
        sin_nxt = -oc;
        cos_nxt = os;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/erm_merge.sv
// Merging stage: forms the nine elements of Rx*Ry*Rz from the three lanes' sine and cosine.
`default_nettype none
module erm_merge (
  input  wire logic               clk,
  input  wire logic [2:0]         en,
  input  wire logic signed [15:0] sx,
  input  wire logic signed [15:0] cx,
  input  wire logic signed [15:0] sy,
  input  wire logic signed [15:0] cy,
  input  wire logic signed [15:0] sz,
  input  wire logic signed [15:0] cz,
  output erm_pkg::mat_t           mat_r
);

  logic signed [31:0] cycz_r, cysz_r, sxsy_r, cxsz_r, cxcz_r;
  logic signed [31:0] sxcy_r, sxsz_r, cxsy_r, sxcz_r, cxcy_r;
  logic signed [15:0] sy1_r, sz1_r, cz1_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cycz_r <= 32'(cy * cz);
      cysz_r <= 32'(cy * sz);
      sxsy_r <= 32'(sx * sy);
      cxsz_r <= 32'(cx * sz);
      cxcz_r <= 32'(cx * cz);
      sxcy_r <= 32'(sx * cy);
      sxsz_r <= 32'(sx * sz);
      cxsy_r <= 32'(cx * sy);
      sxcz_r <= 32'(sx * cz);
      cxcy_r <= 32'(cx * cy);
      sy1_r  <= sy;
      sz1_r  <= sz;
      cz1_r  <= cz;
    end
  end

  logic signed [47:0] sxsycz_r, sxsysz_r, cxsycz_r, cxsysz_r;
  logic signed [47:0] t00_r, t01_r, t02_r, t10_r, t11_r, t12_r;
  logic signed [47:0] t20_r, t21_r, t22_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sxsycz_r <= 48'(sxsy_r) * 48'(cz1_r);
      sxsysz_r <= 48'(sxsy_r) * 48'(sz1_r);
      cxsycz_r <= 48'(cxsy_r) * 48'(cz1_r);
      cxsysz_r <= 48'(cxsy_r) * 48'(sz1_r);
      t00_r    <= 48'(cycz_r) <<< 14;
      t01_r    <= -(48'(cysz_r) <<< 14);
      t02_r    <= 48'(sy1_r) <<< 28;
      t10_r    <= 48'(cxsz_r) <<< 14;
      t11_r    <= 48'(cxcz_r) <<< 14;
      t12_r    <= -(48'(sxcy_r) <<< 14);
      t20_r    <= 48'(sxsz_r) <<< 14;
      t21_r    <= 48'(sxcz_r) <<< 14;
      t22_r    <= 48'(cxcy_r) <<< 14;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mat_r.m00 <= erm_pkg::finish(t00_r);
      mat_r.m01 <= erm_pkg::finish(t01_r);
      mat_r.m02 <= erm_pkg::finish(t02_r);
      mat_r.m10 <= erm_pkg::finish(sxsycz_r + t10_r);
      mat_r.m11 <= erm_pkg::finish(t11_r - sxsysz_r);
      mat_r.m12 <= erm_pkg::finish(t12_r);
      mat_r.m20 <= erm_pkg::finish(t20_r - cxsycz_r);
      mat_r.m21 <= erm_pkg::finish(t21_r + cxsysz_r);
      mat_r.m22 <= erm_pkg::finish(t22_r);
    end
  end

endmodule
`default_nettype wire

// File: rtl/euler_rotation_matrix.sv
// Top level of the Euler rotation matrix block (R = Rx*Ry*Rz, Q1.14 out).
`default_nettype none
// Takes one angle triple per cycle while in_ready is high; matrices leave in order. Three
// identical lanes, one per angle, reduce the angle to an octant and evaluate sine and
// cosine with a 13-stage pipeline of 32-bit multipliers and reciprocal dividers; a
// 3-stage merge forms the nine products and rounds and saturates them. Every stage
// has its own valid bit, so bubbles close up under backpressure and a stalled output
// only blocks input once all 16 stages are full.
module euler_rotation_matrix (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_angle_x,
  input  wire logic signed [15:0] in_angle_y,
  input  wire logic signed [15:0] in_angle_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_m00,
  output logic signed [15:0]      out_m01,
  output logic signed [15:0]      out_m02,
  output logic signed [15:0]      out_m10,
  output logic signed [15:0]      out_m11,
  output logic signed [15:0]      out_m12,
  output logic signed [15:0]      out_m20,
  output logic signed [15:0]      out_m21,
  output logic signed [15:0]      out_m22
);

  localparam int NS = 16;

  logic [NS-1:0] v_r;
  logic [NS:0]   rdy;
  logic [NS-1:0] en;

  always_comb begin
    rdy[NS] = out_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    en = rdy[NS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];

  logic signed [15:0] sx, cx, sy, cy, sz, cz;

  erm_sincos u_lane_x (
    .clk   (clk),
    .en    (en[12:0]),
    .angle (in_angle_x),
    .sin_r (sx),
    .cos_r (cx)
  );

  erm_sincos u_lane_y (
    .clk   (clk),
    .en    (en[12:0]),
    .angle (in_angle_y),
    .sin_r (sy),
    .cos_r (cy)
  );

  erm_sincos u_lane_z (
    .clk   (clk),
    .en    (en[12:0]),
    .angle (in_angle_z),
    .sin_r (sz),
    .cos_r (cz)
  );

  erm_pkg::mat_t mat;

  erm_merge u_merge (
    .clk   (clk),
    .en    (en[15:13]),
    .sx    (sx),
    .cx    (cx),
    .sy    (sy),
    .cy    (cy),
    .sz    (sz),
    .cz    (cz),
    .mat_r (mat)
  );

  assign out_m00 = mat.m00;
  assign out_m01 = mat.m01;
  assign out_m02 = mat.m02;
  assign out_m10 = mat.m10;
  assign out_m11 = mat.m11;
  assign out_m12 = mat.m12;
  assign out_m20 = mat.m20;
  assign out_m21 = mat.m21;
  assign out_m22 = mat.m22;

  a_ready_when_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(&v_r) |-> in_ready)
    else $error("input stalled with an empty stage");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !v_r[NS-2]) |=> !out_valid)
    else $error("transfer repeated");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_m11 <= 16'sd16384 && out_m11 >= -16'sd16384 &&
                   out_m20 <= 16'sd16384 && out_m20 >= -16'sd16384))
    else $error("element out of range");

endmodule
`default_nettype wire

// File: test/euler_rotation_matrix_test.sv
// Testbench for euler_rotation_matrix: directed table plus random angle triples, checked
// against a built-in Euler matrix predictor under random input gaps and output stalls.
module euler_rotation_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] in_angle_x;
  logic signed [15:0] in_angle_y;
  logic signed [15:0] in_angle_z;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] out_m00, out_m01, out_m02, out_m10, out_m11, out_m12;
  logic signed [15:0] out_m20, out_m21, out_m22;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    bit                 has_exp;
    erm_pkg::mat_t      exp_mat;
  } angle_row_t;

  erm_pkg::mat_t matrix_fifo[$];
  int     errors;
  bit     stim_done;
  bit     long_hold;

  euler_rotation_matrix i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_m00(out_m00), .out_m01(out_m01), .out_m02(out_m02),
    .out_m10(out_m10), .out_m11(out_m11), .out_m12(out_m12),
    .out_m20(out_m20), .out_m21(out_m21), .out_m22(out_m22)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned q30_mult(longint unsigned a, longint unsigned b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic longint unsigned rdiv(longint unsigned v, longint unsigned n);
    return (v + n / 2) / n;
  endfunction

  function automatic void octant_trig(int u, output longint s_q14, output longint c_q14);
    longint unsigned x, x2, s, c;
    x = longint'(u) * 292818;
    x2 = q30_mult(x, x);
    s = 64'd1073741824 - rdiv(x2, 42);
    s = 64'd1073741824 - rdiv(q30_mult(x2, s), 20);
    s = 64'd1073741824 - rdiv(q30_mult(x2, s), 6);
    s = q30_mult(x, s);
    c = 64'd1073741824 - rdiv(x2, 56);
    c = 64'd1073741824 - rdiv(q30_mult(x2, c), 30);
    c = 64'd1073741824 - rdiv(q30_mult(x2, c), 12);
    c = 64'd1073741824 - rdiv(q30_mult(x2, c), 2);
    s_q14 = longint'((s + 32768) >> 16);
    c_q14 = longint'((c + 32768) >> 16);
  endfunction

  function automatic void angle_trig(logic signed [15:0] a, output longint s, output longint c);
    int r, q, f;
    longint t;
    r = int'(a) % 23040;
    if (r < 0) r += 23040;
    q = r / 5760;
    f = r % 5760;
    if (f > 2880) octant_trig(5760 - f, c, s);
    else octant_trig(f, s, c);
    case (q)
      1: begin t = s; s = c; c = -t; end
      2: begin s = -s; c = -c; end
      3: begin t = s; s = -c; c = t; end
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] q42_to_q14(longint v);
    longint r;
    r = (v + 64'sd134217728) >>> 28;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return 16'(r);
  endfunction

  function automatic erm_pkg::mat_t euler_matrix(logic signed [15:0] ax,
                                                 logic signed [15:0] ay,
                                                 logic signed [15:0] az);
    longint sx, cx, sy, cy, sz, cz;
    longint k;
    erm_pkg::mat_t m;
    k = 16384;
    angle_trig(ax, sx, cx);
    angle_trig(ay, sy, cy);
    angle_trig(az, sz, cz);
    m.m00 = q42_to_q14(cy * cz * k);
    m.m01 = q42_to_q14(-cy * sz * k);
    m.m02 = q42_to_q14(sy * k * k);
    m.m10 = q42_to_q14(sx * sy * cz + cx * sz * k);
    m.m11 = q42_to_q14(cx * cz * k - sx * sy * sz);
    m.m12 = q42_to_q14(-sx * cy * k);
    m.m20 = q42_to_q14(sx * sz * k - cx * sy * cz);
    m.m21 = q42_to_q14(sx * cz * k + cx * sy * sz);
    m.m22 = q42_to_q14(cx * cy * k);
    return m;
  endfunction

  function automatic erm_pkg::mat_t diag_matrix(logic signed [15:0] d0,
                                                logic signed [15:0] d1,
                                                logic signed [15:0] d2);
    erm_pkg::mat_t m;
    m = '0;
    m.m00 = d0;
    m.m11 = d1;
    m.m22 = d2;
    return m;
  endfunction

  task automatic send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                             logic signed [15:0] az, bit has_exp, erm_pkg::mat_t exp_mat);
    erm_pkg::mat_t pred;
    pred = euler_matrix(ax, ay, az);
    if (has_exp && pred !== exp_mat) begin
      $display("%0t predictor row %0d %0d %0d: expected %h actual %h",
               $time, ax, ay, az, exp_mat, pred);
      errors++;
    end
    in_valid <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    matrix_fifo.push_back(has_exp ? exp_mat : pred);
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_gap();
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      in_angle_x <= 16'($urandom);
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'(23040 * $urandom_range(0, 2) - 23040 + 5760 * $urandom_range(0, 3)
                    + $urandom_range(0, 2) - 1);
      1: return 16'(2880 + 5760 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  angle_row_t angle_table[$];
  localparam logic signed [15:0] P1 = erm_pkg::Q14_POS;
  localparam logic signed [15:0] N1 = erm_pkg::Q14_NEG;

  initial begin
    erm_pkg::mat_t none;
    int burst;
    none = '0;
    errors = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_angle_x = '0;
    in_angle_y = '0;
    in_angle_z = '0;
    angle_table = '{
      '{16'sd0, 16'sd0, 16'sd0, 1'b1, diag_matrix(P1, P1, P1)},
      '{16'sd23040, 16'sd0, 16'sd0, 1'b1, diag_matrix(P1, P1, P1)},
      '{-16'sd23040, 16'sd23040, -16'sd23040, 1'b1, diag_matrix(P1, P1, P1)},
      '{16'sd11520, 16'sd0, 16'sd0, 1'b1, diag_matrix(P1, N1, N1)},
      '{16'sd0, 16'sd11520, 16'sd0, 1'b1, diag_matrix(N1, P1, N1)},
      '{16'sd0, 16'sd0, -16'sd11520, 1'b1, diag_matrix(N1, N1, P1)},
      '{16'sd5760, 16'sd0, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd5760, 16'sd0, 1'b0, none},
      '{16'sd0, 16'sd0, 16'sd5760, 1'b0, none},
      '{16'sd17280, 16'sd17280, 16'sd17280, 1'b0, none},
      '{16'sd2880, 16'sd2881, 16'sd2879, 1'b0, none},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, none},
      '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, none},
      '{16'sh7fff, 16'sh8000, 16'sd1, 1'b0, none},
      '{-16'sd1, 16'sd1, -16'sd1, 1'b0, none},
      '{16'sd2880, 16'sd2880, 16'sd2880, 1'b0, none},
      '{-16'sd2880, 16'sd8640, 16'sd20160, 1'b0, none},
      '{16'sh5555, 16'shaaaa, 16'sh0f0f, 1'b0, none}
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (angle_table[i]) begin
      send_angles(angle_table[i].ax, angle_table[i].ay, angle_table[i].az,
                  angle_table[i].has_exp, angle_table[i].exp_mat);
      send_gap();
    end
    for (int n = 0; n < 1700;) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < 1700; b++, n++)
        send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0, none);
      send_gap();
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int hold;
    out_ready = 1'b0;
    long_hold = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!long_hold && matrix_fifo.size() > 12) begin
        long_hold = 1'b1;
        out_ready <= 1'b0;
        for (hold = 0; hold < 60; hold++) @(negedge clk);
      end
      case (($time / 400) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 4) != 0);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    erm_pkg::mat_t got, exp_mat;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_m00, out_m01, out_m02, out_m10, out_m11, out_m12,
              out_m20, out_m21, out_m22};
      if (matrix_fifo.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual %h", $time, got);
        errors++;
      end else begin
        exp_mat = matrix_fifo.pop_front();
        if (got.m00 !== exp_mat.m00) begin
          $display("%0t m00 expected %0d actual %0d", $time, exp_mat.m00, got.m00); errors++;
        end
        if (got.m01 !== exp_mat.m01) begin
          $display("%0t m01 expected %0d actual %0d", $time, exp_mat.m01, got.m01); errors++;
        end
        if (got.m02 !== exp_mat.m02) begin
          $display("%0t m02 expected %0d actual %0d", $time, exp_mat.m02, got.m02); errors++;
        end
        if (got.m10 !== exp_mat.m10) begin
          $display("%0t m10 expected %0d actual %0d", $time, exp_mat.m10, got.m10); errors++;
        end
        if (got.m11 !== exp_mat.m11) begin
          $display("%0t m11 expected %0d actual %0d", $time, exp_mat.m11, got.m11); errors++;
        end
        if (got.m12 !== exp_mat.m12) begin
          $display("%0t m12 expected %0d actual %0d", $time, exp_mat.m12, got.m12); errors++;
        end
        if (got.m20 !== exp_mat.m20) begin
          $display("%0t m20 expected %0d actual %0d", $time, exp_mat.m20, got.m20); errors++;
        end
        if (got.m21 !== exp_mat.m21) begin
          $display("%0t m21 expected %0d actual %0d", $time, exp_mat.m21, got.m21); errors++;
        end
        if (got.m22 !== exp_mat.m22) begin
          $display("%0t m22 expected %0d actual %0d", $time, exp_mat.m22, got.m22); errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (matrix_fifo.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule
